>>> design/dnsp_pkg.sv
`timescale 1ns / 1ps

package dnsp_pkg;

  localparam int unsigned DNSP_MAX_MESSAGE_BYTES = 512;
  localparam int unsigned DNSP_QUEUE_DEPTH       = 2;

  // config port
  localparam int unsigned CFG_ADDR_W  = 3;
  localparam int unsigned CFG_DATA_W  = 32;
  localparam logic [15:0] DNSP_ID_RESET = 16'd1234;

  typedef enum logic [0:0] {
    REG_EXPECTED_ID = 1'b0
  } cfg_reg_t;

  typedef enum logic [3:0] {
    PH_HEADER = 4'd0,
    PH_QNAME  = 4'd1,
    PH_QLABEL = 4'd2,
    PH_QPTR   = 4'd3,
    PH_QTAIL  = 4'd4,
    PH_ANAME  = 4'd5,
    PH_ALABEL = 4'd6,
    PH_APTR   = 4'd7,
    PH_AFIXED = 4'd8,
    PH_RDATA  = 4'd9,
    PH_DONE   = 4'd10,
    PH_HALT   = 4'd11
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK           = 2'd0,
    ST_SHORT_HEADER = 2'd1,
    ST_ID_MISMATCH  = 2'd2,
    ST_TRUNCATED    = 2'd3
  } status_t;

  // byte positions inside fixed-size fields
  localparam logic [3:0] HDR_ID_LO      = 4'd1;
  localparam logic [3:0] HDR_QDCOUNT_LO = 4'd5;
  localparam logic [3:0] HDR_ANCOUNT_LO = 4'd7;
  localparam logic [3:0] HDR_LAST       = 4'd11;
  localparam logic [3:0] QTAIL_LAST     = 4'd3;
  localparam logic [3:0] AFIXED_TYPE_LO = 4'd1;
  localparam logic [3:0] AFIXED_LAST    = 4'd9;

  localparam logic [7:0] LABEL_PTR_MASK = 8'hC0;

  // one queued byte: live is low once the message is past the size limit
  typedef struct packed {
    logic [7:0] octet;
    logic       last;
    logic       live;
  } dnsp_item_t;

endpackage

>>> design/dnsp_in_if.sv
`timescale 1ns / 1ps

interface dnsp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] message_byte;
  logic       end_of_message;

  modport source (output valid, output message_byte, output end_of_message, input ready);
  modport sink   (input valid, input message_byte, input end_of_message, output ready);
endinterface

>>> design/dnsp_out_if.sv
`timescale 1ns / 1ps

interface dnsp_out_if;
  logic        valid;
  logic        ready;
  logic        data_valid;
  logic [15:0] record_type;
  logic [15:0] record_index;
  logic [7:0]  data_octet;
  logic [8:0]  data_offset;
  logic        data_last;
  logic        message_done;
  logic [1:0]  status;

  modport source (
    output valid, output data_valid, output record_type, output record_index,
    output data_octet, output data_offset, output data_last, output message_done,
    output status, input ready
  );
  modport sink (
    input valid, input data_valid, input record_type, input record_index,
    input data_octet, input data_offset, input data_last, input message_done,
    input status, output ready
  );
endinterface

>>> design/dnsp_front.sv
`timescale 1ns / 1ps

module dnsp_front import dnsp_pkg::*; #(
  parameter int unsigned MAX_MESSAGE_BYTES = DNSP_MAX_MESSAGE_BYTES
) (
  input  logic         clk,
  input  logic         rst_n,
  dnsp_in_if.sink      in_if,
  output logic         push_valid,
  output dnsp_item_t   push_item,
  input  logic         push_ready
);

  localparam int unsigned CNT_W = $clog2(MAX_MESSAGE_BYTES + 1);

  logic [CNT_W-1:0] byte_count_r, byte_count_nxt;
  logic             live;
  logic             accept;

  // bytes past the size limit are passed on with live low; end mark still counts
  assign live       = byte_count_r < CNT_W'(MAX_MESSAGE_BYTES);
  assign in_if.ready = push_ready;
  assign accept     = in_if.valid && push_ready;

  assign push_valid      = in_if.valid;
  assign push_item.octet = in_if.message_byte;
  assign push_item.last  = in_if.end_of_message;
  assign push_item.live  = live;

  always_comb begin
    byte_count_nxt = byte_count_r;
    if (accept) begin
      if (in_if.end_of_message) begin
        byte_count_nxt = '0;
      end else if (live) begin
        byte_count_nxt = byte_count_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_count_r <= '0;
    end else begin
      byte_count_r <= byte_count_nxt;
    end
  end

endmodule

>>> design/dnsp_fifo.sv
`timescale 1ns / 1ps

module dnsp_fifo import dnsp_pkg::*; #(
  parameter int unsigned WIDTH = $bits(dnsp_item_t),
  parameter int unsigned DEPTH = DNSP_QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  input  logic [WIDTH-1:0] push_data,
  output logic             push_ready,
  output logic             pop_valid,
  output logic [WIDTH-1:0] pop_data,
  input  logic             pop_ready
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign push_ready = count_r != CNT_W'(DEPTH);
  assign pop_valid  = count_r != '0;
  assign pop_data   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

>>> design/dnsp_back.sv
`timescale 1ns / 1ps

module dnsp_back import dnsp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [15:0] expected_id,
  input  logic        q_valid,
  input  dnsp_item_t  q_item,
  output logic        q_ready,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_data_valid,
  output logic [15:0] out_record_type,
  output logic [15:0] out_record_index,
  output logic [7:0]  out_data_octet,
  output logic [8:0]  out_data_offset,
  output logic        out_data_last,
  output logic        out_message_done,
  output logic [1:0]  out_status
);

  // parser state
  phase_t      phase_r, phase_nxt, phase_step;
  logic [3:0]  field_count_r, field_count_nxt;
  logic [15:0] word_shift_r, word_shift_nxt;
  logic [15:0] questions_left_r, questions_left_nxt;
  logic [15:0] answers_left_r, answers_left_nxt;
  logic [7:0]  label_skip_r, label_skip_nxt;
  logic [15:0] current_type_r, current_type_nxt;
  logic [15:0] rdata_left_r, rdata_left_nxt;
  logic [8:0]  rdata_pos_r, rdata_pos_nxt;
  logic [15:0] answer_number_r, answer_number_nxt;
  logic [1:0]  error_code_r, error_code_nxt;

  // result register
  logic        out_valid_r, out_valid_nxt;
  logic        data_valid_r, data_valid_nxt;
  logic [15:0] record_type_r, record_type_nxt;
  logic [15:0] record_index_r, record_index_nxt;
  logic [7:0]  data_octet_r, data_octet_nxt;
  logic [8:0]  data_offset_r, data_offset_nxt;
  logic        data_last_r, data_last_nxt;
  logic        message_done_r, message_done_nxt;
  logic [1:0]  status_r, status_nxt;

  logic        can_take, go, step, emit, ends;
  logic [15:0] ws_cat, q_dec, a_dec, rl_dec;
  logic [7:0]  ls_dec;
  logic        is_ptr, is_zero, hdr_end, id_bad;
  status_t     msg_status;

  assign can_take = !out_valid_r || out_ready;
  assign q_ready  = can_take;
  assign go       = q_valid && can_take;
  assign step     = go && q_item.live;
  assign ends     = go && q_item.last;
  assign emit     = step && (phase_r == PH_RDATA);

  assign ws_cat  = {word_shift_r[7:0], q_item.octet};
  assign q_dec   = questions_left_r - 16'd1;
  assign a_dec   = answers_left_r - 16'd1;
  assign rl_dec  = rdata_left_r - 16'd1;
  assign ls_dec  = label_skip_r - 8'd1;
  assign is_ptr  = (q_item.octet & LABEL_PTR_MASK) == LABEL_PTR_MASK;
  assign is_zero = q_item.octet == 8'd0;
  assign hdr_end = field_count_r >= HDR_LAST;
  assign id_bad  = (field_count_r == HDR_ID_LO) && (ws_cat != expected_id);

  // phase sequencing
  always_comb begin
    phase_step = phase_r;
    if (step) begin
      unique case (phase_r)
        PH_HEADER: begin
          if (hdr_end) begin
            if (error_code_r != ST_OK)        phase_step = PH_HALT;
            else if (questions_left_r != '0)  phase_step = PH_QNAME;
            else if (answers_left_r != '0)    phase_step = PH_ANAME;
            else                              phase_step = PH_DONE;
          end
        end
        PH_QNAME: begin
          if (is_ptr)       phase_step = PH_QPTR;
          else if (is_zero) phase_step = PH_QTAIL;
          else              phase_step = PH_QLABEL;
        end
        PH_QLABEL: begin
          if (ls_dec == '0) phase_step = PH_QNAME;
        end
        PH_QPTR: phase_step = PH_QTAIL;
        PH_QTAIL: begin
          if (field_count_r >= QTAIL_LAST) begin
            if (q_dec != '0)                phase_step = PH_QNAME;
            else if (answers_left_r != '0)  phase_step = PH_ANAME;
            else                            phase_step = PH_DONE;
          end
        end
        PH_ANAME: begin
          if (is_ptr)       phase_step = PH_APTR;
          else if (is_zero) phase_step = PH_AFIXED;
          else              phase_step = PH_ALABEL;
        end
        PH_ALABEL: begin
          if (ls_dec == '0) phase_step = PH_ANAME;
        end
        PH_APTR: phase_step = PH_AFIXED;
        PH_AFIXED: begin
          if (field_count_r >= AFIXED_LAST) begin
            if (ws_cat != '0)      phase_step = PH_RDATA;
            else if (a_dec != '0)  phase_step = PH_ANAME;
            else                   phase_step = PH_DONE;
          end
        end
        PH_RDATA: begin
          if (rl_dec == '0) phase_step = (a_dec != '0) ? PH_ANAME : PH_DONE;
        end
        PH_DONE, PH_HALT: phase_step = phase_r;
        default: phase_step = phase_r;
      endcase
    end
    phase_nxt = ends ? PH_HEADER : phase_step;
  end

  // counters, captured fields, result
  always_comb begin
    field_count_nxt    = field_count_r;
    word_shift_nxt     = word_shift_r;
    questions_left_nxt = questions_left_r;
    answers_left_nxt   = answers_left_r;
    label_skip_nxt     = label_skip_r;
    current_type_nxt   = current_type_r;
    rdata_left_nxt     = rdata_left_r;
    rdata_pos_nxt      = rdata_pos_r;
    answer_number_nxt  = answer_number_r;
    error_code_nxt     = error_code_r;

    if (step) begin
      case (phase_r)
        PH_HEADER: begin
          word_shift_nxt = ws_cat;
          if (id_bad) begin
            error_code_nxt = ST_ID_MISMATCH;
          end else if (field_count_r == HDR_QDCOUNT_LO) begin
            questions_left_nxt = ws_cat;
          end else if (field_count_r == HDR_ANCOUNT_LO) begin
            answers_left_nxt = ws_cat;
          end
          field_count_nxt = hdr_end ? 4'd0 : field_count_r + 4'd1;
        end
        PH_QNAME, PH_ANAME: begin
          if (!is_ptr) begin
            if (is_zero) field_count_nxt = 4'd0;
            else         label_skip_nxt  = q_item.octet;
          end
        end
        PH_QLABEL, PH_ALABEL: label_skip_nxt = ls_dec;
        PH_QPTR, PH_APTR:     field_count_nxt = 4'd0;
        PH_QTAIL: begin
          if (field_count_r >= QTAIL_LAST) begin
            field_count_nxt    = 4'd0;
            questions_left_nxt = q_dec;
          end else begin
            field_count_nxt = field_count_r + 4'd1;
          end
        end
        PH_AFIXED: begin
          word_shift_nxt = ws_cat;
          if (field_count_r == AFIXED_TYPE_LO) current_type_nxt = ws_cat;
          if (field_count_r >= AFIXED_LAST) begin
            field_count_nxt = 4'd0;
            rdata_left_nxt  = ws_cat;
            rdata_pos_nxt   = 9'd0;
            if (ws_cat == '0) begin
              answer_number_nxt = answer_number_r + 16'd1;
              answers_left_nxt  = a_dec;
            end
          end else begin
            field_count_nxt = field_count_r + 4'd1;
          end
        end
        PH_RDATA: begin
          rdata_pos_nxt  = rdata_pos_r + 9'd1;
          rdata_left_nxt = rl_dec;
          if (rl_dec == '0) begin
            answer_number_nxt = answer_number_r + 16'd1;
            answers_left_nxt  = a_dec;
          end
        end
        default: ;
      endcase
    end

    // status reflects the state after this byte, before the restart
    if (phase_step == PH_HEADER)            msg_status = ST_SHORT_HEADER;
    else if (error_code_nxt == ST_ID_MISMATCH) msg_status = ST_ID_MISMATCH;
    else if (phase_step != PH_DONE)         msg_status = ST_TRUNCATED;
    else                                    msg_status = ST_OK;

    if (ends) begin
      field_count_nxt    = '0;
      word_shift_nxt     = '0;
      questions_left_nxt = '0;
      answers_left_nxt   = '0;
      label_skip_nxt     = '0;
      current_type_nxt   = '0;
      rdata_left_nxt     = '0;
      rdata_pos_nxt      = '0;
      answer_number_nxt  = '0;
      error_code_nxt     = ST_OK;
    end

    out_valid_nxt    = out_valid_r;
    data_valid_nxt   = data_valid_r;
    record_type_nxt  = record_type_r;
    record_index_nxt = record_index_r;
    data_octet_nxt   = data_octet_r;
    data_offset_nxt  = data_offset_r;
    data_last_nxt    = data_last_r;
    message_done_nxt = message_done_r;
    status_nxt       = status_r;
    if (can_take) begin
      out_valid_nxt    = emit || ends;
      data_valid_nxt   = emit;
      record_type_nxt  = emit ? current_type_r : 16'd0;
      record_index_nxt = emit ? answer_number_r : 16'd0;
      data_octet_nxt   = emit ? q_item.octet : 8'd0;
      data_offset_nxt  = emit ? rdata_pos_r : 9'd0;
      data_last_nxt    = emit && (rdata_left_r == 16'd1);
      message_done_nxt = ends;
      status_nxt       = ends ? msg_status : ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r          <= PH_HEADER;
      field_count_r    <= '0;
      word_shift_r     <= '0;
      questions_left_r <= '0;
      answers_left_r   <= '0;
      label_skip_r     <= '0;
      current_type_r   <= '0;
      rdata_left_r     <= '0;
      rdata_pos_r      <= '0;
      answer_number_r  <= '0;
      error_code_r     <= ST_OK;
      out_valid_r      <= 1'b0;
    end else begin
      phase_r          <= phase_nxt;
      field_count_r    <= field_count_nxt;
      word_shift_r     <= word_shift_nxt;
      questions_left_r <= questions_left_nxt;
      answers_left_r   <= answers_left_nxt;
      label_skip_r     <= label_skip_nxt;
      current_type_r   <= current_type_nxt;
      rdata_left_r     <= rdata_left_nxt;
      rdata_pos_r      <= rdata_pos_nxt;
      answer_number_r  <= answer_number_nxt;
      error_code_r     <= error_code_nxt;
      out_valid_r      <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_valid_r   <= data_valid_nxt;
    record_type_r  <= record_type_nxt;
    record_index_r <= record_index_nxt;
    data_octet_r   <= data_octet_nxt;
    data_offset_r  <= data_offset_nxt;
    data_last_r    <= data_last_nxt;
    message_done_r <= message_done_nxt;
    status_r       <= status_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_data_valid   = data_valid_r;
  assign out_record_type  = record_type_r;
  assign out_record_index = record_index_r;
  assign out_data_octet   = data_octet_r;
  assign out_data_offset  = data_offset_r;
  assign out_data_last    = data_last_r;
  assign out_message_done = message_done_r;
  assign out_status       = status_r;

`ifndef SYNTH
  a_result_has_cause: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !message_done_r |-> data_valid_r)
    else $error("result without rdata byte or message end");

  a_status_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !message_done_r |-> status_r == ST_OK)
    else $error("status set on mid-message result");

  a_end_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    ends |=> phase_r == PH_HEADER && field_count_r == 4'd0 && error_code_r == ST_OK)
    else $error("parser not restarted after message end");

  a_field_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    field_count_r <= HDR_LAST)
    else $error("field counter out of range");
`endif

endmodule

>>> design/dns_response_answer_parser.sv
`timescale 1ns / 1ps
// An accepted byte is written into the queue, then the parser retires it into the result
// register, from which its result transfers; the queue is not fall-through.
// Throughput: one byte per cycle while out_ready holds; the parser retires one byte a cycle.
// Reset: synchronous, active-low rst_n; clears the parser, queue and byte counter,
// and sets expected_id to 1234. No clearing pass; input ready from the first edge after reset.

module dns_response_answer_parser import dnsp_pkg::*; #(
  parameter int unsigned MAX_MESSAGE_BYTES = DNSP_MAX_MESSAGE_BYTES,
  parameter int unsigned QUEUE_DEPTH       = DNSP_QUEUE_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  dnsp_in_if.sink               in_if,
  dnsp_out_if.source            out_if,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  // ---------------------------------------------------------------------------
  // Config register: expected transaction id at byte address 0.
  // Low two address bits select a byte lane and are not decoded.
  // ---------------------------------------------------------------------------
  logic [15:0] expected_id_r, expected_id_nxt;
  logic        reg_hit;
  logic        cfg_write;

  assign pready    = 1'b1;
  assign reg_hit   = paddr[CFG_ADDR_W-1:2] == REG_EXPECTED_ID;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = reg_hit ? {{(CFG_DATA_W-16){1'b0}}, expected_id_r} : '0;

  always_comb begin
    expected_id_nxt = expected_id_r;
    if (cfg_write && reg_hit) begin
      expected_id_nxt = pwdata[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expected_id_r <= DNSP_ID_RESET;
    end else begin
      expected_id_r <= expected_id_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Front: counts bytes of the message and tags those past the size limit,
  // then pushes each transfer into the byte queue.
  // ---------------------------------------------------------------------------
  logic       push_valid, push_ready;
  dnsp_item_t push_item;

  dnsp_front #(
    .MAX_MESSAGE_BYTES(MAX_MESSAGE_BYTES)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_if),
    .push_valid(push_valid),
    .push_item (push_item),
    .push_ready(push_ready)
  );

  // ---------------------------------------------------------------------------
  // Queue: decouples input acceptance from result back-pressure.
  // ---------------------------------------------------------------------------
  logic       pop_valid, pop_ready;
  dnsp_item_t pop_item;

  dnsp_fifo #(
    .WIDTH($bits(dnsp_item_t)),
    .DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_valid(push_valid),
    .push_data (push_item),
    .push_ready(push_ready),
    .pop_valid (pop_valid),
    .pop_data  (pop_item),
    .pop_ready (pop_ready)
  );

  // ---------------------------------------------------------------------------
  // Back: header / question / answer walker with the result register.
  // A byte is retired whenever the result register is free or being drained.
  // ---------------------------------------------------------------------------
  dnsp_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .expected_id     (expected_id_r),
    .q_valid         (pop_valid),
    .q_item          (pop_item),
    .q_ready         (pop_ready),
    .out_valid       (out_if.valid),
    .out_ready       (out_if.ready),
    .out_data_valid  (out_if.data_valid),
    .out_record_type (out_if.record_type),
    .out_record_index(out_if.record_index),
    .out_data_octet  (out_if.data_octet),
    .out_data_offset (out_if.data_offset),
    .out_data_last   (out_if.data_last),
    .out_message_done(out_if.message_done),
    .out_status      (out_if.status)
  );

endmodule
